FILE: rtl/edv_pkg.sv
// ----------------------------------------------------------------------------
// edv_pkg
// Shared types and constants of the echo distance validator: register map,
// reset values, distance conversion constants and the result word.
// ----------------------------------------------------------------------------
package edv_pkg;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FILTER_CYCLES = 3'd0;
    localparam logic [2:0] REG_NOISE_TOL_PCT = 3'd1;
    localparam logic [2:0] REG_FAR_THRESH    = 3'd2;
    localparam logic [2:0] REG_NEAR_THRESH   = 3'd3;
    localparam logic [2:0] REG_CONTACT_THRESH = 3'd4;

    // Reset values of the registers
    localparam logic [3:0] RST_FILTER_CYCLES  = 4'd3;
    localparam logic [6:0] RST_NOISE_TOL_PCT  = 7'd10;
    localparam logic [8:0] RST_FAR_THRESH     = 9'd50;
    localparam logic [8:0] RST_NEAR_THRESH    = 9'd20;
    localparam logic [8:0] RST_CONTACT_THRESH = 9'd4;

    // Echo width window giving a distance of 2..400 cm
    localparam logic [31:0] MIN_ECHO_US = 32'd117;
    localparam logic [31:0] MAX_ECHO_US = 32'd23381;

    // floor(w * 343 / 20000) == (w * DIST_RECIP) >> DIST_SHIFT for w <= 23381
    localparam logic [23:0] DIST_RECIP = 24'd9207337;
    localparam int          DIST_SHIFT = 29;

    // Tolerance limits in cm
    localparam logic [8:0] SHORT_RANGE_CM = 9'd20;
    localparam logic [8:0] SHORT_TOL_CM   = 9'd2;
    localparam logic [8:0] CHANGE_STEP_CM = 9'd1;

    typedef enum logic [2:0] {
        PH_NONE        = 3'd0,
        PH_DISTANT     = 3'd1,
        PH_APPROACHING = 3'd2,
        PH_NEAR        = 3'd3,
        PH_CONTACT     = 3'd4
    } t_phase;

    typedef struct packed {
        logic [3:0] filter_cycles;
        logic [6:0] noise_tol_pct;
        logic [8:0] far_cm;
        logic [8:0] near_cm;
        logic [8:0] contact_cm;
    } t_cfg;

    typedef struct packed {
        logic [8:0] reference_cm;
        logic       has_reference;
        logic       confirmed;
        logic       object_detected;
        logic       changed;
        t_phase     phase;
    } t_result;

endpackage

FILE: rtl/edv_dist_conv.sv
// ----------------------------------------------------------------------------
// edv_dist_conv
// Converts an echo width in microseconds to a distance in centimetres and
// flags whether it falls inside the usable 2..400 cm window.
// ----------------------------------------------------------------------------
module edv_dist_conv
    import edv_pkg::*;
#(
    parameter int WIDTH_BITS = 16
) (
    input  logic [WIDTH_BITS-1:0] i_width_us,
    output logic                  o_valid,
    output logic [8:0]            o_dist_cm
);

    logic [31:0] w_width_ext;
    logic [38:0] w_prod;
    logic [38:0] w_scaled;

    assign w_width_ext = 32'(i_width_us);

    // Window check on the full width; zero is below the window
    assign o_valid = (w_width_ext >= MIN_ECHO_US) && (w_width_ext <= MAX_ECHO_US);

    // Divide by 20000 through a reciprocal; exact across the window
    assign w_prod    = 39'(w_width_ext[14:0]) * 39'(DIST_RECIP);
    assign w_scaled  = w_prod >> DIST_SHIFT;
    assign o_dist_cm = w_scaled[8:0];

endmodule

FILE: rtl/edv_tracker.sv
// ----------------------------------------------------------------------------
// edv_tracker
// Holds the reference distance, confidence counter and stable flag, and
// forms the result word for each processed reading.
// ----------------------------------------------------------------------------
module edv_tracker
    import edv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_action,
    input  logic       i_dist_valid,
    input  logic [8:0] i_dist_cm,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    logic [8:0]  r_ref;
    logic        r_has_ref;
    logic [3:0]  r_cnt;
    logic        r_stable;
    logic [8:0]  n_ref;
    logic        n_has_ref;
    logic [3:0]  n_cnt;
    logic        n_stable;

    logic [8:0]  w_diff;
    logic [15:0] w_tol_prod;
    logic [8:0]  w_tol;
    logic        w_agree;
    logic [3:0]  w_cnt_dec;
    logic [3:0]  w_cnt_inc;
    logic        w_confirmed;
    logic        w_changed;
    logic        w_detected;
    t_phase      w_phase;

    // Distance between reading and reference
    assign w_diff = (i_dist_cm > r_ref) ? (i_dist_cm - r_ref) : (r_ref - i_dist_cm);

    // Tolerance: fixed at short range, else min(ref*pct/100, 4)
    assign w_tol_prod = 16'(r_ref) * 16'(i_cfg.noise_tol_pct);
    always_comb begin
        if (r_ref <= SHORT_RANGE_CM) begin
            w_tol = SHORT_TOL_CM;
        end else if (w_tol_prod >= 16'd400) begin
            w_tol = 9'd4;
        end else if (w_tol_prod >= 16'd300) begin
            w_tol = 9'd3;
        end else if (w_tol_prod >= 16'd200) begin
            w_tol = 9'd2;
        end else if (w_tol_prod >= 16'd100) begin
            w_tol = 9'd1;
        end else begin
            w_tol = 9'd0;
        end
    end
    assign w_agree = (w_diff <= w_tol);

    assign w_cnt_dec = (r_cnt != 4'd0) ? (r_cnt - 4'd1) : 4'd0;
    assign w_cnt_inc = (r_cnt < i_cfg.filter_cycles) ? (r_cnt + 4'd1) : r_cnt;

    // Next state of the filter
    always_comb begin
        n_ref       = r_ref;
        n_has_ref   = r_has_ref;
        n_cnt       = r_cnt;
        n_stable    = r_stable;
        w_confirmed = 1'b0;
        w_changed   = 1'b0;
        if (i_action) begin
            n_ref     = '0;
            n_has_ref = 1'b0;
            n_cnt     = '0;
            n_stable  = 1'b0;
        end else if (!i_dist_valid) begin
            n_cnt = w_cnt_dec;
            if (w_cnt_dec == 4'd0) begin
                n_stable = 1'b0;
            end
        end else if (!r_has_ref) begin
            n_ref     = i_dist_cm;
            n_has_ref = 1'b1;
            n_cnt     = 4'd1;
            n_stable  = 1'b0;
        end else if (w_agree) begin
            n_cnt = w_cnt_inc;
            if (w_cnt_inc >= i_cfg.filter_cycles) begin
                n_ref       = i_dist_cm;
                n_stable    = 1'b1;
                w_confirmed = 1'b1;
                w_changed   = (w_diff > CHANGE_STEP_CM);
            end
        end else begin
            n_cnt = w_cnt_dec;
            if (w_cnt_dec == 4'd0) begin
                n_stable  = 1'b0;
                w_changed = 1'b1;
                n_ref     = i_dist_cm;
                n_cnt     = 4'd1;
            end
        end
    end

    // Approach phase from the updated reference
    assign w_detected = n_has_ref && n_stable;
    always_comb begin
        if (!w_detected) begin
            w_phase = PH_NONE;
        end else if (n_ref >= i_cfg.far_cm) begin
            w_phase = PH_DISTANT;
        end else if (n_ref >= i_cfg.near_cm) begin
            w_phase = PH_APPROACHING;
        end else if (n_ref >= i_cfg.contact_cm) begin
            w_phase = PH_NEAR;
        end else begin
            w_phase = PH_CONTACT;
        end
    end

    always_comb begin
        o_result.reference_cm    = n_ref;
        o_result.has_reference   = n_has_ref;
        o_result.confirmed       = w_confirmed;
        o_result.object_detected = w_detected;
        o_result.changed         = w_changed;
        o_result.phase           = w_phase;
    end

    // Commit the state when a reading leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref     <= '0;
            r_has_ref <= 1'b0;
            r_cnt     <= '0;
            r_stable  <= 1'b0;
        end else if (i_fire) begin
            r_ref     <= n_ref;
            r_has_ref <= n_has_ref;
            r_cnt     <= n_cnt;
            r_stable  <= n_stable;
        end
    end

endmodule

FILE: rtl/edv_apb_regs.sv
// ----------------------------------------------------------------------------
// edv_apb_regs
// APB register block holding the filter and threshold settings.
// ----------------------------------------------------------------------------
module edv_apb_regs
    import edv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    // Write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_cycles <= RST_FILTER_CYCLES;
            r_cfg.noise_tol_pct <= RST_NOISE_TOL_PCT;
            r_cfg.far_cm        <= RST_FAR_THRESH;
            r_cfg.near_cm       <= RST_NEAR_THRESH;
            r_cfg.contact_cm    <= RST_CONTACT_THRESH;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                REG_FILTER_CYCLES:  r_cfg.filter_cycles <= pwdata[3:0];
                REG_NOISE_TOL_PCT:  r_cfg.noise_tol_pct <= pwdata[6:0];
                REG_FAR_THRESH:     r_cfg.far_cm        <= pwdata[8:0];
                REG_NEAR_THRESH:    r_cfg.near_cm       <= pwdata[8:0];
                REG_CONTACT_THRESH: r_cfg.contact_cm    <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[4:2])
            REG_FILTER_CYCLES:  prdata = 32'(r_cfg.filter_cycles);
            REG_NOISE_TOL_PCT:  prdata = 32'(r_cfg.noise_tol_pct);
            REG_FAR_THRESH:     prdata = 32'(r_cfg.far_cm);
            REG_NEAR_THRESH:    prdata = 32'(r_cfg.near_cm);
            REG_CONTACT_THRESH: prdata = 32'(r_cfg.contact_cm);
            default:            prdata = '0;
        endcase
    end

endmodule

FILE: rtl/echo_distance_validator_core.sv
// ----------------------------------------------------------------------------
// echo_distance_validator_core
// Validates ultrasonic echo readings against a filtered reference distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (i_action, i_echo_width_us) are taken on i_in_valid when
//   o_in_stall is low. i_action high clears the filter state and yields an
//   all-zero result; otherwise the echo width is turned into centimetres,
//   filtered and classified into an approach phase.
//   One result word per input word leaves on o_out_valid, taken when
//   i_out_stall is low.
//   Path: a taken word sits in the input register, is processed and loaded
//   into the result register once that is empty or i_out_stall is low.
//   Throughput: one word per cycle while i_out_stall is low; the filter
//   update between the input and result registers is combinational.
//   While the receiver stalls the result register holds; a new word is
//   still taken into an empty input register, after which o_in_stall rises.
//   Settings are to be written over the APB port while the block is idle;
//   the block itself does not enforce this.
//   Reset (synchronous, active low) empties both registers, clears the
//   filter state and loads the default settings.
// ----------------------------------------------------------------------------
module echo_distance_validator_core
    import edv_pkg::*;
#(
    parameter int WIDTH_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [WIDTH_BITS-1:0] i_echo_width_us,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [8:0]            o_reference_cm,
    output logic                  o_has_reference,
    output logic                  o_confirmed,
    output logic                  o_object_detected,
    output logic                  o_changed,
    output logic [2:0]            o_phase,
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic                  r_in_valid;
    logic                  r_in_action;
    logic [WIDTH_BITS-1:0] r_in_width;
    logic                  r_out_valid;
    t_result               r_out;

    logic    w_advance;
    logic    w_fire;
    logic    w_dist_valid;
    logic [8:0] w_dist_cm;
    t_cfg    w_cfg;
    t_result w_result;

    // Pipeline flow control
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_advance;
    assign o_in_stall = r_in_valid && !w_advance;

    edv_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    edv_dist_conv #(
        .WIDTH_BITS (WIDTH_BITS)
    ) u_dist (
        .i_width_us (r_in_width),
        .o_valid    (w_dist_valid),
        .o_dist_cm  (w_dist_cm)
    );

    edv_tracker u_tracker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (w_fire),
        .i_action     (r_in_action),
        .i_dist_valid (w_dist_valid),
        .i_dist_cm    (w_dist_cm),
        .i_cfg        (w_cfg),
        .o_result     (w_result)
    );

    // Input register: load on accept, empty when the word moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_action <= i_action;
            r_in_width  <= i_echo_width_us;
        end
    end

    // Result register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_reference_cm    = r_out.reference_cm;
    assign o_has_reference   = r_out.has_reference;
    assign o_confirmed       = r_out.confirmed;
    assign o_object_detected = r_out.object_detected;
    assign o_changed         = r_out.changed;
    assign o_phase           = r_out.phase;

`ifndef NO_ASSERTIONS
    // Detection needs a reference
    a_detect_has_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_object_detected) |-> o_has_reference)
        else $error("object detected without reference");

    // A phase is reported exactly when an object is detected
    a_phase_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_phase != PH_NONE) == o_object_detected))
        else $error("phase and detection disagree");

    // A confirmed reading leaves the filter stable
    a_confirm_detect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_confirmed) |-> o_object_detected)
        else $error("confirmed reading not detected");

    // No reference means a zero distance
    a_noref_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_reference) |-> (o_reference_cm == '0))
        else $error("reference distance without reference");
`endif

endmodule

FILE: dv/echo_distance_validator_tb.sv
// ----------------------------------------------------------------------------
// echo_distance_validator testbench
// Drives echo widths and clear actions into the validator core, predicts each
// result word from its own copy of the filter state and settings, and checks
// every result field by field. Settings are changed over APB between phases
// while both channels idle and stall at random, with hold-off stretches.
// ----------------------------------------------------------------------------
module testbench;
    import edv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DRAIN_SLACK = 4;
    localparam int unsigned MAX_PRINTS  = 40;

    logic        i_clk;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic        o_in_stall;
    logic        i_action          = 1'b0;
    logic [15:0] i_echo_width_us   = '0;
    logic        o_out_valid;
    logic        i_out_stall       = 1'b0;
    logic [8:0]  o_reference_cm;
    logic        o_has_reference;
    logic        o_confirmed;
    logic        o_object_detected;
    logic        o_changed;
    logic [2:0]  o_phase;
    logic        psel              = 1'b0;
    logic        penable           = 1'b0;
    logic        pwrite            = 1'b0;
    logic [4:0]  paddr             = '0;
    logic [31:0] pwdata            = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predictor copy of the settings
    logic [3:0] cfg_filter  = RST_FILTER_CYCLES;
    logic [6:0] cfg_tol_pct = RST_NOISE_TOL_PCT;
    logic [8:0] cfg_far     = RST_FAR_THRESH;
    logic [8:0] cfg_near    = RST_NEAR_THRESH;
    logic [8:0] cfg_contact = RST_CONTACT_THRESH;

    // Predictor copy of the filter state
    logic [8:0] ref_cm     = '0;
    logic       ref_held   = 1'b0;
    logic [3:0] agree_cnt  = '0;
    logic       ref_stable = 1'b0;

    t_result verdicts_q[$];

    // Traffic control shared between the test tasks and the stall process
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;
    int unsigned hold_left = 0;

    int unsigned mismatches     = 0;
    int unsigned words_sent     = 0;
    int unsigned settings_count = 0;
    int unsigned confirm_count  = 0;
    int unsigned replace_count  = 0;
    bit [4:0]    phases_seen    = '0;

    echo_distance_validator_core #(
        .WIDTH_BITS (16)
    ) u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_action          (i_action),
        .i_echo_width_us   (i_echo_width_us),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_reference_cm    (o_reference_cm),
        .o_has_reference   (o_has_reference),
        .o_confirmed       (o_confirmed),
        .o_object_detected (o_object_detected),
        .o_changed         (o_changed),
        .o_phase           (o_phase),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Work out the result word of one echo word and advance the filter state
    function automatic t_result predict_echo(input bit act, input logic [15:0] width);
        t_result     res;
        int unsigned dist_cm;
        int unsigned gap;
        int unsigned tol;
        bit          in_range;
        res = '0;
        if (act) begin
            ref_cm     = '0;
            ref_held   = 1'b0;
            agree_cnt  = '0;
            ref_stable = 1'b0;
            return res;
        end
        dist_cm  = (32'(width) * 343) / 20000;
        in_range = (width != 0) && (dist_cm >= 2) && (dist_cm <= 400);
        if (!in_range) begin
            if (agree_cnt != 0)
                agree_cnt--;
            if (agree_cnt == 0)
                ref_stable = 1'b0;
        end else if (!ref_held) begin
            ref_cm     = dist_cm[8:0];
            ref_held   = 1'b1;
            agree_cnt  = 4'd1;
            ref_stable = 1'b0;
        end else begin
            gap = (dist_cm > ref_cm) ? dist_cm - ref_cm : ref_cm - dist_cm;
            if (ref_cm <= 20) begin
                tol = 2;
            end else begin
                tol = (32'(ref_cm) * 32'(cfg_tol_pct)) / 100;
                if (tol > 4)
                    tol = 4;
            end
            if (gap <= tol) begin
                if (agree_cnt < cfg_filter)
                    agree_cnt++;
                if (agree_cnt >= cfg_filter) begin
                    res.changed   = (gap > 1);
                    res.confirmed = 1'b1;
                    ref_cm        = dist_cm[8:0];
                    ref_stable    = 1'b1;
                    confirm_count++;
                end
            end else begin
                if (agree_cnt != 0)
                    agree_cnt--;
                if (agree_cnt == 0) begin
                    ref_stable  = 1'b0;
                    res.changed = 1'b1;
                    ref_cm      = dist_cm[8:0];
                    agree_cnt   = 4'd1;
                    replace_count++;
                end
            end
        end
        res.reference_cm    = ref_cm;
        res.has_reference   = ref_held;
        res.object_detected = ref_held && ref_stable;
        if (!res.object_detected)
            res.phase = PH_NONE;
        else if (ref_cm >= cfg_far)
            res.phase = PH_DISTANT;
        else if (ref_cm >= cfg_near)
            res.phase = PH_APPROACHING;
        else if (ref_cm >= cfg_contact)
            res.phase = PH_NEAR;
        else
            res.phase = PH_CONTACT;
        phases_seen[res.phase] = 1'b1;
        return res;
    endfunction

    // Receiver: random stalls, hold-off stretches counted here, or none at all
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (rx_steady) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 33);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdicts_q.size() == 0) begin
                flag_mismatch("result word with none expected", o_reference_cm, 0);
            end else begin
                want = verdicts_q.pop_front();
                if (o_reference_cm != want.reference_cm)
                    flag_mismatch("reference_cm", o_reference_cm, want.reference_cm);
                if (o_has_reference != want.has_reference)
                    flag_mismatch("has_reference", o_has_reference, want.has_reference);
                if (o_confirmed != want.confirmed)
                    flag_mismatch("confirmed", o_confirmed, want.confirmed);
                if (o_object_detected != want.object_detected)
                    flag_mismatch("object_detected", o_object_detected,
                                  want.object_detected);
                if (o_changed != want.changed)
                    flag_mismatch("changed", o_changed, want.changed);
                if (o_phase != want.phase)
                    flag_mismatch("phase", o_phase, want.phase);
            end
        end
    end

    // Offer one word after a random gap; valid stays high until the next gap
    task automatic push_word(input bit act, input logic [15:0] width);
        int unsigned idle;
        idle = 0;
        if (!tx_steady)
            while ($urandom_range(99) < 33)
                idle++;
        if (idle > 0) begin
            i_in_valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_echo_width_us <= width;
        do @(posedge i_clk); while (o_in_stall);
        verdicts_q.push_back(predict_echo(act, width));
        words_sent++;
    endtask

    // Hold the sender until every expected word has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (verdicts_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_FILTER_CYCLES:  cfg_filter  = value[3:0];
            REG_NOISE_TOL_PCT:  cfg_tol_pct = value[6:0];
            REG_FAR_THRESH:     cfg_far     = value[8:0];
            REG_NEAR_THRESH:    cfg_near    = value[8:0];
            REG_CONTACT_THRESH: cfg_contact = value[8:0];
            default: ;
        endcase
    endtask

    task automatic cfg_read_check(input logic [2:0] idx, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        if (got != want)
            flag_mismatch($sformatf("register %0d read back", idx), got, want);
    endtask

    // Load a full set of settings once the block has gone quiet
    task automatic apply_settings(input logic [3:0] filt, input logic [6:0] pct,
                                  input logic [8:0] far, input logic [8:0] near,
                                  input logic [8:0] contact);
        drain();
        cfg_write(REG_FILTER_CYCLES, 32'(filt));
        cfg_write(REG_NOISE_TOL_PCT, 32'(pct));
        cfg_write(REG_FAR_THRESH, 32'(far));
        cfg_write(REG_NEAR_THRESH, 32'(near));
        cfg_write(REG_CONTACT_THRESH, 32'(contact));
        cfg_read_check(REG_FILTER_CYCLES, 32'(filt));
        cfg_read_check(REG_NOISE_TOL_PCT, 32'(pct));
        cfg_read_check(REG_FAR_THRESH, 32'(far));
        cfg_read_check(REG_NEAR_THRESH, 32'(near));
        cfg_read_check(REG_CONTACT_THRESH, 32'(contact));
        settings_count++;
    endtask

    // Any echo width that lands on exactly this distance
    function automatic logic [15:0] width_for(input int unsigned cm);
        int unsigned lo;
        int unsigned hi;
        lo = (cm * 20000 + 342) / 343;
        hi = ((cm + 1) * 20000 + 342) / 343 - 1;
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic int unsigned clamp_cm(input int cm);
        if (cm < 2)
            return 2;
        if (cm > 400)
            return 400;
        return cm;
    endfunction

    // Aim at short range, the thresholds, or anywhere in the valid window
    function automatic int unsigned pick_distance();
        int          base;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 20) begin
            case ($urandom_range(2))
                0:       base = int'(cfg_far);
                1:       base = int'(cfg_near);
                default: base = int'(cfg_contact);
            endcase
            base = base + int'($urandom_range(4)) - 2;
        end else if (sel < 55) begin
            base = int'($urandom_range(30, 2));
        end else begin
            base = int'($urandom_range(400, 2));
        end
        return clamp_cm(base);
    endfunction

    // Mostly runs of readings around a target, some drifting in, plus noise
    task automatic run_random_words(input int unsigned count);
        int unsigned done;
        int unsigned sel;
        int unsigned run_len;
        int          target;
        bit          drifting;
        done = 0;
        while (done < count) begin
            sel = $urandom_range(99);
            if (sel < 80) begin
                target   = int'(pick_distance());
                run_len  = $urandom_range(int'(cfg_filter) + 6, 2);
                drifting = ($urandom_range(99) < 30);
                repeat (run_len) begin
                    if ($urandom_range(99) < 6)
                        push_word(1'b0, 16'd0);
                    else if ($urandom_range(99) < 75)
                        push_word(1'b0, width_for(clamp_cm(target +
                                  int'($urandom_range(2)) - 1)));
                    else
                        push_word(1'b0, width_for(clamp_cm(target +
                                  int'($urandom_range(10)) - 5)));
                    if (drifting)
                        target = target - int'($urandom_range(2));
                    done++;
                end
            end else if (sel < 88) begin
                push_word(1'b0, 16'($urandom_range(16'hFFFF)));
                done++;
            end else if (sel < 93) begin
                case ($urandom_range(2))
                    0:       push_word(1'b0, 16'd0);
                    1:       push_word(1'b0, 16'($urandom_range(116, 1)));
                    default: push_word(1'b0, 16'($urandom_range(16'hFFFF, 23382)));
                endcase
                done++;
            end else if (sel < 97) begin
                push_word(1'b1, 16'($urandom_range(16'hFFFF)));
                done++;
            end else begin
                case ($urandom_range(3))
                    0:       push_word(1'b0, width_for(2));
                    1:       push_word(1'b0, width_for(400));
                    2:       push_word(1'b0, width_for(20));
                    default: push_word(1'b0, width_for(21));
                endcase
                done++;
            end
        end
    endtask

    // Reset values, field extremes and each special case at default settings
    task automatic test_field_edges();
        cfg_read_check(REG_FILTER_CYCLES, 32'(RST_FILTER_CYCLES));
        cfg_read_check(REG_NOISE_TOL_PCT, 32'(RST_NOISE_TOL_PCT));
        cfg_read_check(REG_FAR_THRESH, 32'(RST_FAR_THRESH));
        cfg_read_check(REG_NEAR_THRESH, 32'(RST_NEAR_THRESH));
        cfg_read_check(REG_CONTACT_THRESH, 32'(RST_CONTACT_THRESH));
        // no echo, then distances below the window
        push_word(1'b0, 16'd0);
        push_word(1'b0, 16'd1);
        push_word(1'b0, 16'd116);
        // first valid reading, agreement, confirmation in the contact zone
        push_word(1'b0, 16'd117);
        push_word(1'b0, 16'd117);
        push_word(1'b0, 16'd175);
        // widest width and just past 400 cm, counter runs down to zero
        push_word(1'b0, 16'hFFFF);
        push_word(1'b0, 16'd23382);
        push_word(1'b0, 16'd0);
        // clear with every width bit set
        push_word(1'b1, 16'hFFFF);
        // top of the window, confirm as distant, then a 4 cm step
        push_word(1'b0, 16'd23381);
        push_word(1'b0, 16'd23381);
        push_word(1'b0, 16'd23381);
        push_word(1'b0, width_for(396));
        // outside tolerance until the reference is replaced, again at 30 cm, then confirmed
        push_word(1'b0, width_for(390));
        push_word(1'b0, width_for(390));
        push_word(1'b0, width_for(390));
        push_word(1'b0, width_for(30));
        push_word(1'b0, width_for(30));
        push_word(1'b0, width_for(31));
        // clear with no width, then confirm as near
        push_word(1'b1, 16'd0);
        push_word(1'b0, width_for(10));
        push_word(1'b0, width_for(10));
        push_word(1'b0, width_for(10));
        push_word(1'b0, width_for(22));
    endtask

    // Thresholds at both ends of their range with filter depths 1 and 15
    task automatic test_threshold_extremes();
        apply_settings(4'd1, 7'd0, 9'd400, 9'd400, 9'd400);
        run_random_words(150);
        apply_settings(4'd15, 7'd100, 9'd0, 9'd0, 9'd0);
        run_random_words(150);
    endtask

    // A zero filter depth confirms every agreeing reading; percentage beyond 100
    task automatic test_filter_extremes();
        apply_settings(4'd0, 7'd127, 9'd10, 9'd300, 9'd200);
        run_random_words(150);
        apply_settings(4'd2, 7'd25, 9'd150, 9'd60, 9'd10);
        run_random_words(100);
    endtask

    // Long receiver hold-off with a busy sender, then a stretch with no gaps
    task automatic test_backpressure();
        tx_steady = 1'b1;
        hold_left = 64;
        run_random_words(24);
        drain();
        rx_steady = 1'b1;
        run_random_words(120);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Random ordered thresholds and filter settings
    task automatic test_random_settings();
        logic [8:0] t_a;
        logic [8:0] t_b;
        logic [8:0] t_c;
        repeat (2) begin
            t_c = 9'($urandom_range(40));
            t_b = t_c + 9'($urandom_range(100));
            t_a = t_b + 9'($urandom_range(260 - int'(t_b) + 140));
            if (t_a > 400)
                t_a = 9'd400;
            apply_settings(4'($urandom_range(15, 1)), 7'($urandom_range(100)),
                           t_a, t_b, t_c);
            run_random_words(110);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_field_edges();
        test_threshold_extremes();
        test_filter_extremes();
        test_backpressure();
        test_random_settings();
        drain();
        $display("Checked %0d echo words under %0d settings: %0d confirmations, %0d replacements",
                 words_sent, settings_count + 1, confirm_count, replace_count);
        $display("Phases reached (contact..none): %05b, mismatches: %0d",
                 phases_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/edv_pkg.sv
rtl/edv_dist_conv.sv
rtl/edv_tracker.sv
rtl/edv_apb_regs.sv
rtl/echo_distance_validator_core.sv
dv/echo_distance_validator_tb.sv
